>>> src/lrb_pkg.sv
// Shared types and constants for the lossy ring buffer.
`timescale 1ns / 1ps

package lrb_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int GUARD_W        = 4;
	localparam int CNT_W          = 32;
	// sequence index arithmetic: 32-bit signed positions plus headroom for +1 and differences
	localparam int IDX_W          = CNT_W + 2;
	localparam int POS_W          = 32;
	localparam int GUARD_VALS     = 1 << GUARD_W;

	typedef enum logic [1:0] {
		ST_WRITTEN   = 2'd0,
		ST_READ_OK   = 2'd1,
		ST_NO_WRITER = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

endpackage

>>> src/lrb_in_if.sv
// Input channel: one write or read request per transfer.
`timescale 1ns / 1ps

interface lrb_in_if import lrb_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [DATA_WIDTH-1:0] write_data;

	modport source (output valid, output mode, output write_data, input ready);
	modport sink   (input valid, input mode, input write_data, output ready);
endinterface

>>> src/lrb_out_if.sv
// Result channel: status, read word and both running counters per transfer.
`timescale 1ns / 1ps

interface lrb_out_if import lrb_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [DATA_WIDTH-1:0] read_data;
	logic [CNT_W-1:0]      dropped_total;
	logic [CNT_W-1:0]      not_ready_total;

	modport source (output valid, output status, output read_data, output dropped_total,
		output not_ready_total, input ready);
	modport sink   (input valid, input status, input read_data, input dropped_total,
		input not_ready_total, output ready);
endinterface

>>> src/lossy_ring_buffer_guarded_reader.sv
// Lossy ring buffer with guarded reader: top level, index logic and ring memory.
`timescale 1ns / 1ps

// Single-writer, single-reader ring of DEPTH words that overwrites its oldest entry.
// Each transfer on "item" is a write (mode 0) or a read (mode 1) and yields exactly one
// transfer on "result". A read returns the next word after the previous read, but never
// one of the ready_guard newest words; a reader that fell behind the oldest held word
// jumps forward and the skipped words are added to dropped_total. Reads that return
// nothing bump not_ready_total. Both counters saturate at all ones. A write steps
// through accept and result load. A read that returns a word steps through accept,
// position update together with the synchronous memory read, drop-count update and
// result load; a read that returns nothing skips the drop-count update. So the ring
// memory read and the position compare ahead of it set the read time. A new
// item is accepted while the previous result still sits in the output register; the
// block then holds its next result until that register is taken. The memory needs no
// clear: its contents only matter once written. ready_guard may be rewritten only while
// idle.
module lossy_ring_buffer_guarded_reader import lrb_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [GUARD_W-1:0] cfg_wr_data,
	lrb_in_if.sink             item,
	lrb_out_if.source          result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [POS_W-1:0] IDX_MAX = POS_W'(32'h7FFF_FFFF);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_FETCH  = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		slot_inc = (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	// ---------------------------------------------------------------- state
	state_t                  state_q;
	logic [GUARD_W-1:0]      guard_q;
	logic signed [POS_W-1:0] lw_q;        // newest written sequence index, -1 = none
	logic [AW-1:0]           lw_slot_q;   // lw_q mod DEPTH while lw_q >= 0
	logic signed [POS_W-1:0] rp_q;        // last read sequence index
	logic [AW-1:0]           rp_slot_q;   // rp_q mod DEPTH while rp_q >= 0
	logic                    first_q;
	logic [CNT_W-1:0]        drop_cnt_q;
	logic [CNT_W-1:0]        empty_cnt_q;

	// read-side pipeline registers
	logic signed [IDX_W-1:0] cand_s1, ready_s1, tail_s1;
	logic [AW-1:0]           cand_slot_s1, ready_slot_s1, tail_slot_s1;
	logic                    no_writer_s1;
	status_t                 status_s2;
	logic signed [IDX_W-1:0] skipped_s2;

	// output register
	logic                    res_valid_q;
	status_t                 res_status_q;
	logic [DATA_WIDTH-1:0]   res_data_q;
	logic [CNT_W-1:0]        res_drop_q;
	logic [CNT_W-1:0]        res_empty_q;
	logic                    res_load;

	// ring memory
	logic [DATA_WIDTH-1:0]   ring_mem [DEPTH];
	logic [DATA_WIDTH-1:0]   rd_data_q;
	logic                    mem_wr_en, mem_rd_en;
	logic [AW-1:0]           mem_wr_slot, mem_rd_slot;

	// guard mod DEPTH, worked out at elaboration for every guard value
	logic [AW-1:0] guard_mod [GUARD_VALS];
	for (genvar g = 0; g < GUARD_VALS; g++) begin : g_guard_mod
		localparam int GM = g % DEPTH;
		assign guard_mod[g] = AW'(GM);
	end

	// ---------------------------------------------------------------- index math at accept
	logic                    accept;
	logic signed [IDX_W-1:0] lw_ext, rp_ext, ready_c, tail_c, cand_c;
	logic [AW-1:0]           gm_c, ready_slot_c, tail_slot_c, step_slot_c;
	logic signed [POS_W-1:0] w_idx_c;
	logic [AW-1:0]           w_slot_c;

	assign accept = item.valid && item.ready;

	always_comb begin
		lw_ext  = IDX_W'(lw_q);
		rp_ext  = IDX_W'(rp_q);
		ready_c = lw_ext - $signed({{(IDX_W-GUARD_W){1'b0}}, guard_q});
		tail_c  = lw_ext - IDX_W'(DEPTH - 1);
		cand_c  = first_q ? ready_c : rp_ext + IDX_W'(1);

		gm_c = guard_mod[guard_q];
		if (lw_slot_q >= gm_c) begin
			ready_slot_c = lw_slot_q - gm_c;
		end else begin
			ready_slot_c = AW'((AW+1)'(lw_slot_q) + (AW+1)'(DEPTH) - (AW+1)'(gm_c));
		end
		tail_slot_c = slot_inc(lw_slot_q);
		// a read stepping up from a negative position gets slot 0, the slot of index 0
		step_slot_c = rp_q[POS_W-1] ? '0 : slot_inc(rp_slot_q);

		// index wraps to zero past the largest positive value
		if (lw_q == IDX_MAX || lw_q[POS_W-1]) begin
			w_slot_c = '0;
		end else begin
			w_slot_c = slot_inc(lw_slot_q);
		end
		w_idx_c = (lw_q == IDX_MAX) ? '0 : lw_q + POS_W'(1);
	end

	// ---------------------------------------------------------------- position decision
	logic                    not_ready_d;
	logic signed [IDX_W-1:0] pos_d;
	logic [AW-1:0]           pos_slot_d;

	always_comb begin
		not_ready_d = cand_s1 > ready_s1;
		if (cand_s1 < tail_s1) begin
			pos_d      = tail_s1;
			pos_slot_d = tail_slot_s1;
		end else begin
			pos_d      = cand_s1;
			pos_slot_d = cand_slot_s1;
		end
	end

	// saturating drop add
	logic [IDX_W-1:0] drop_sum;
	assign drop_sum = {{(IDX_W-CNT_W){1'b0}}, drop_cnt_q} + $unsigned(skipped_s2);

	assign mem_wr_en   = accept && !item.mode;
	assign mem_wr_slot = w_slot_c;
	assign mem_rd_en   = (state_q == S_DECIDE) && !no_writer_s1 && !not_ready_d
		&& !pos_d[IDX_W-1];
	assign mem_rd_slot = pos_slot_d;

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			ring_mem[mem_wr_slot] <= item.write_data;
		end
		if (mem_rd_en) begin
			rd_data_q <= ring_mem[mem_rd_slot];
		end
	end

	// ---------------------------------------------------------------- payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_s1       <= cand_c;
			ready_s1      <= ready_c;
			tail_s1       <= tail_c;
			cand_slot_s1  <= first_q ? ready_slot_c : step_slot_c;
			ready_slot_s1 <= ready_slot_c;
			tail_slot_s1  <= tail_slot_c;
			no_writer_s1  <= lw_q[POS_W-1];
			if (!item.mode) begin
				status_s2 <= ST_WRITTEN;
			end
		end
		if (state_q == S_DECIDE) begin
			if (no_writer_s1) begin
				status_s2 <= ST_NO_WRITER;
			end else if (not_ready_d || pos_d[IDX_W-1]) begin
				status_s2 <= ST_NOT_READY;
			end else begin
				status_s2 <= ST_READ_OK;
			end
			skipped_s2 <= pos_d - rp_ext - IDX_W'(1);
		end
	end

	// ---------------------------------------------------------------- control
	// result register loads when the emit state finds it free or being taken
	assign res_load = (state_q == S_EMIT) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			guard_q     <= '0;
			lw_q        <= '1;
			lw_slot_q   <= '0;
			rp_q        <= '1;
			rp_slot_q   <= '0;
			first_q     <= 1'b1;
			drop_cnt_q  <= '0;
			empty_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				guard_q <= cfg_wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!item.mode) begin
							lw_q      <= w_idx_c;
							lw_slot_q <= w_slot_c;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (no_writer_s1) begin
						first_q     <= 1'b1;
						empty_cnt_q <= sat_inc(empty_cnt_q);
						state_q     <= S_EMIT;
					end else begin
						first_q <= 1'b0;
						if (not_ready_d) begin
							// caught up with the guarded limit: park there
							rp_q        <= POS_W'(ready_s1);
							rp_slot_q   <= ready_slot_s1;
							empty_cnt_q <= sat_inc(empty_cnt_q);
							state_q     <= S_EMIT;
						end else begin
							rp_q      <= POS_W'(pos_d);
							rp_slot_q <= pos_slot_d;
							if (pos_d[IDX_W-1]) begin
								empty_cnt_q <= sat_inc(empty_cnt_q);
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_FETCH: begin
					// only forward jumps count; stepping back leaves the count alone
					if (!skipped_s2[IDX_W-1] && skipped_s2 != '0) begin
						drop_cnt_q <= (drop_sum[IDX_W-1:CNT_W] != '0) ? '1
							: drop_sum[CNT_W-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= status_s2;
			res_data_q   <= (status_s2 == ST_READ_OK) ? rd_data_q : '0;
			res_drop_q   <= drop_cnt_q;
			res_empty_q  <= empty_cnt_q;
		end
	end

	assign item.ready             = (state_q == S_IDLE);
	assign result.valid           = res_valid_q;
	assign result.status          = res_status_q;
	assign result.read_data       = res_data_q;
	assign result.dropped_total   = res_drop_q;
	assign result.not_ready_total = res_empty_q;

	// ---------------------------------------------------------------- assertions
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en || mem_rd_en) |->
		({1'b0, mem_wr_slot} < (AW+1)'(DEPTH) && {1'b0, mem_rd_slot} < (AW+1)'(DEPTH)))
		else $error("ring slot out of range");

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		drop_cnt_q >= $past(drop_cnt_q))
		else $error("drop count decreased");

	a_empty_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		empty_cnt_q >= $past(empty_cnt_q))
		else $error("not-ready count decreased");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q != ST_READ_OK) |-> (res_data_q == '0))
		else $error("read data nonzero on a result without a read");

endmodule
